@@ sv/itoa_pkg.sv @@
// itoa_pkg: shared types and constants for the integer to decimal text block.
// Used by itoa_ctrl, itoa_datapath and integer_to_decimal_text. No dependencies.
package itoa_pkg;

   localparam int VALUE_WIDTH   = 64;
   localparam int IN_WIDTH      = 64;
   localparam int BITS_PER_STEP = 4;
   localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int MAG_W         = STEPS * BITS_PER_STEP;
   localparam int NUM_DIGITS    = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_W         = NUM_DIGITS * 4;
   localparam int PTR_W         = $clog2(NUM_DIGITS);
   localparam int STEP_CW       = (STEPS > 1) ? $clog2(STEPS) : 1;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic scan;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic ptr_zero;
      logic out_free;
   } stat_type;

endpackage

@@ sv/itoa_ctrl.sv @@
// itoa_ctrl: controller state machine; sequences load, conversion, digit scan
// and character emission. Depends on itoa_pkg.
module itoa_ctrl
   import itoa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type            state_ff, state_in;
   logic [STEP_CW-1:0]   step_ff, step_in;
   logic                 step_last;

   assign step_last = (step_ff == STEP_CW'(STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (step_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            state_in = stat.neg ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (stat.out_free) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (stat.out_free && stat.ptr_zero) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_stall      = 1'b1;
      step_in        = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            step_in   = '0;
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            step_in     = step_ff + 1'b1;
         end
         ST_SCAN:  cmd.scan       = 1'b1;
         ST_SIGN:  cmd.emit_sign  = stat.out_free;
         ST_DIGIT: cmd.emit_digit = stat.out_free;
         default:  cmd            = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.convert, cmd.scan, cmd.emit_sign, cmd.emit_digit}))
      else $error("more than one datapath command");

   a_load_converts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_CONVERT) && (step_ff == '0))
      else $error("load not followed by conversion");

   a_sign_neg: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sign |-> stat.neg)
      else $error("sign emitted for non-negative item");

   a_last_digit_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && stat.ptr_zero) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after last digit");
`endif

endmodule

@@ sv/itoa_datapath.sv @@
// itoa_datapath: magnitude register, shift-add-3 BCD converter (4 bits per
// cycle), leading digit scan and output register. Depends on itoa_pkg.
module itoa_datapath
   import itoa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [IN_WIDTH-1:0] req_value,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [7:0]          rsp_character,
   output logic                rsp_last
);

   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   bcd_type                bcd_ff, bcd_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] val_w;
   logic [VALUE_WIDTH-1:0] mag_w;
   bcd_type                dd_bcd;
   logic [MAG_W-1:0]       dd_mag;
   logic [PTR_W-1:0]       lead_idx;
   logic                   out_free;

   assign val_w    = req_value[VALUE_WIDTH-1:0];
   assign mag_w    = val_w[VALUE_WIDTH-1] ? (~val_w + 1'b1) : val_w;
   assign out_free = !valid_ff || !rsp_stall;

   // shift-add-3 over BITS_PER_STEP bits
   always_comb begin
      dd_bcd = bcd_ff;
      dd_mag = mag_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (dd_bcd[d] >= 4'd5) dd_bcd[d] = dd_bcd[d] + 4'd3;
         end
         dd_bcd = BCD_W'({dd_bcd, dd_mag[MAG_W-1]});
         dd_mag = {dd_mag[MAG_W-2:0], 1'b0};
      end
   end

   // highest nonzero digit, zero if all digits are zero
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d] != 4'd0) lead_idx = PTR_W'(d);
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      bcd_in   = bcd_ff;
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (cmd.load) begin
         neg_in = val_w[VALUE_WIDTH-1];
         mag_in = MAG_W'(mag_w);
         bcd_in = '0;
      end
      if (cmd.convert) begin
         bcd_in = dd_bcd;
         mag_in = dd_mag;
      end
      if (cmd.scan) ptr_in = lead_idx;
      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = CHAR_MINUS;
         last_in  = 1'b0;
      end
      if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = CHAR_ZERO | {4'b0000, bcd_ff[ptr_ff]};
         last_in  = (ptr_ff == '0);
         ptr_in   = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      ptr_ff  <= ptr_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign stat.neg      = neg_ff;
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.out_free = out_free;

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

`ifndef ASSERT_OFF
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (bcd_ff == '0))
      else $error("digit register not cleared on load");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> out_free)
      else $error("output register overwritten");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (bcd_ff[ptr_ff] <= 4'd9))
      else $error("digit out of range");
`endif

endmodule

@@ sv/integer_to_decimal_text.sv @@
// integer_to_decimal_text: top level, joins itoa_ctrl and itoa_datapath.
// Depends on itoa_pkg, itoa_ctrl, itoa_datapath.
//
// Usage:
//   Request channel (req_valid, req_stall, req_value): one signed integer per
//   item; only the low VALUE_WIDTH bits are used, sign-extended from the top.
//   Response channel (rsp_valid, rsp_stall, rsp_character, rsp_last): the
//   decimal text as ASCII, most significant digit first, a leading '-' for
//   negative values, rsp_last set on the final character. Zero gives '0'.
//   Conversion: after acceptance, STEPS (16) steps of 4 bits each through the
//   shift-add-3 converter and a leading digit scan, then the first character
//   appears in the output register. One item is in work at a time; the pace
//   is set by the converter and the one-character output register.
//   req_stall is low only while no item is in work; the next item is taken
//   while the last character of the previous one still waits in the output
//   register. A stalled response holds its character until taken, and the
//   block waits on it. Reset (synchronous, active high) empties the output
//   register and returns the controller to idle.
module integer_to_decimal_text
   import itoa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [IN_WIDTH-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_character,
   output logic                rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   itoa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_value     (req_value),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
